@@ sv/msct_pkg.sv @@
// Shared types and constants for the multi-slot callback timer.
`timescale 1ns / 1ps

package msct_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_OVERFLOW = 2'd0;
    localparam logic [1:0] OP_SET      = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    // Result kinds
    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    // Fired slots reported per tick, and width of the report counter
    localparam int COUNT_W     = 4;
    localparam int MAX_RESULTS = 8;

    // Reset value of the prescaler and of its reload register
    localparam logic [7:0] PRESCALE_RESET = 8'd5;

    // Register addresses (word index taken from paddr[2])
    localparam logic REG_OVERFLOWS_PER_TICK = 1'b0;

    // One slot entry as stored in the slot memory
    typedef struct packed {
        logic        repeats;
        logic [15:0] period;
        logic [15:0] countdown;
    } slot_word_t;

endpackage

@@ sv/msct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module msct_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/multi_slot_callback_timer.sv @@
// Top level of the multi-slot callback timer: sequencer, slot memory and APB register.
`timescale 1ns / 1ps

// A table of NUM_SLOTS timer slots driven by commands. start is taken when busy is low;
// opcode selects an overflow event, a set or a clear. The next word is taken at the end of
// the first cycle with busy low. Set walks the active flags from slot 0, one slot per
// cycle, and claims the first free slot below the last one (else the last slot), then
// shows its result word. Clear, an overflow that does not tick, and unused opcodes finish
// in the dispatch state. A tick walks every slot through the slot memory's single read
// port, one slot per cycle behind the registered read, and after the walk shows the final
// word when any slot fires. Each result word sits on kind, slot and last for exactly one
// cycle with strobe high; the receiver cannot stall it, and busy stays high until the
// final word of an item has been shown. Up to MAX_RESULTS fired slots are reported per
// tick, the last one with last set. Active flags live in flops cleared by reset, so no
// clearing pass is needed after reset. overflows_per_tick sits at byte address 0 and takes
// effect at the next prescaler reload.
module multi_slot_callback_timer #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] period,
    input  logic        repeating,
    input  logic [2:0]  slot_number,
    // Result channel
    output logic        strobe,
    output logic        kind,
    output logic [2:0]  slot,
    output logic        last,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int WORD_W = $bits(msct_pkg::slot_word_t);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DISPATCH = 4'b0010,
        ST_FIND     = 4'b0100,
        ST_TICK     = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]                  opt_reg, opt_next;
    logic [7:0]                  prescale_reg, prescale_next;
    logic [NUM_SLOTS-1:0]        active_reg, active_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic                        proc_valid_reg, proc_valid_next;
    logic [SLOT_W-1:0]           proc_idx_reg, proc_idx_next;
    logic                        held_valid_reg, held_valid_next;
    logic [SLOT_W-1:0]           held_slot_reg, held_slot_next;
    logic [msct_pkg::COUNT_W-1:0] count_reg, count_next;

    // Captured command word (payload, no reset)
    logic [1:0]  op_reg, op_next;
    logic [15:0] period_reg, period_next;
    logic        rep_reg, rep_next;
    logic [2:0]  sel_reg, sel_next;

    // Result word
    logic        strobe_reg, strobe_next;
    logic        kind_reg, kind_next;
    logic [2:0]  slot_reg, slot_next;
    logic        last_reg, last_next;

    // Slot memory ports
    logic                 ram_wr_en;
    logic [SLOT_W-1:0]    ram_wr_addr;
    msct_pkg::slot_word_t ram_wr_word;
    logic                 ram_rd_en;
    logic [SLOT_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]    ram_rd_data;
    msct_pkg::slot_word_t rd_word;

    logic              accept;
    logic              cfg_write;
    logic [7:0]        pre_dec;
    logic [15:0]       cd_dec;
    logic [SLOT_W-1:0] idx_slot;
    logic [SLOT_W-1:0] clr_slot;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE) || strobe_reg;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == msct_pkg::REG_OVERFLOWS_PER_TICK) ? {24'd0, opt_reg} : 32'd0;

    assign strobe = strobe_reg;
    assign kind   = kind_reg;
    assign slot   = slot_reg;
    assign last   = last_reg;

    assign rd_word  = msct_pkg::slot_word_t'(ram_rd_data);
    assign pre_dec  = prescale_reg - 8'd1;
    assign cd_dec   = rd_word.countdown - 16'd1;
    assign idx_slot = idx_reg[SLOT_W-1:0];
    assign clr_slot = SLOT_W'(sel_reg);

    msct_ram #(
        .WIDTH(WORD_W),
        .DEPTH(NUM_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_word),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        opt_next        = opt_reg;
        prescale_next   = prescale_reg;
        active_next     = active_reg;
        idx_next        = idx_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        period_next     = period_reg;
        rep_next        = rep_reg;
        sel_next        = sel_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        last_next       = last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_slot;
        ram_wr_word     = '{repeats: rep_reg, period: period_reg, countdown: period_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = idx_slot;

        if (cfg_write && (paddr[2] == msct_pkg::REG_OVERFLOWS_PER_TICK))
        begin
            opt_next = pwdata[7:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Capture the command word
                if (accept)
                begin
                    op_next     = opcode;
                    period_next = period;
                    rep_next    = repeating;
                    sel_next    = slot_number;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                idx_next = '0;
                if (op_reg == msct_pkg::OP_SET)
                begin
                    state_next = ST_FIND;
                end
                else if (op_reg == msct_pkg::OP_CLEAR)
                begin
                    // Drop the slot; numbers past the table are ignored
                    if (32'(sel_reg) < NUM_SLOTS)
                    begin
                        active_next[clr_slot] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
                else if (op_reg == msct_pkg::OP_OVERFLOW)
                begin
                    // Advance the prescaler; a zero starts a tick walk
                    if (pre_dec == 8'd0)
                    begin
                        prescale_next   = opt_reg;
                        count_next      = '0;
                        held_valid_next = 1'b0;
                        state_next      = ST_TICK;
                    end
                    else
                    begin
                        prescale_next = pre_dec;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIND:
            begin
                // Claim the first free slot, or the last slot
                if (!active_reg[idx_slot] || (idx_reg == CNT_W'(NUM_SLOTS - 1)))
                begin
                    ram_wr_en              = 1'b1;
                    active_next[idx_slot]  = (period_reg != 16'd0);
                    strobe_next            = 1'b1;
                    kind_next              = msct_pkg::KIND_SET;
                    slot_next              = 3'(idx_slot);
                    last_next              = 1'b1;
                    state_next             = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_TICK:
            begin
                // Issue the read of the next slot
                if (idx_reg != CNT_W'(NUM_SLOTS))
                begin
                    ram_rd_en       = 1'b1;
                    proc_valid_next = 1'b1;
                    proc_idx_next   = idx_slot;
                    idx_next        = idx_reg + CNT_W'(1);
                end

                // Count down the slot whose word came back
                if (proc_valid_reg && active_reg[proc_idx_reg])
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = proc_idx_reg;
                    ram_wr_word = '{repeats: rd_word.repeats, period: rd_word.period,
                                    countdown: cd_dec};
                    if (cd_dec == 16'd0)
                    begin
                        if (rd_word.repeats)
                        begin
                            ram_wr_word.countdown = rd_word.period;
                        end
                        else
                        begin
                            active_next[proc_idx_reg] = 1'b0;
                        end
                        // Hold the newest fired slot; release the one before it
                        if (count_reg < msct_pkg::COUNT_W'(msct_pkg::MAX_RESULTS))
                        begin
                            if (held_valid_reg)
                            begin
                                strobe_next = 1'b1;
                                kind_next   = msct_pkg::KIND_FIRE;
                                slot_next   = 3'(held_slot_reg);
                                last_next   = 1'b0;
                            end
                            held_valid_next = 1'b1;
                            held_slot_next  = proc_idx_reg;
                            count_next      = count_reg + msct_pkg::COUNT_W'(1);
                        end
                    end
                end

                // Finish the walk and flush the held slot as the final word
                if ((idx_reg == CNT_W'(NUM_SLOTS)) && !proc_valid_reg)
                begin
                    if (held_valid_reg)
                    begin
                        strobe_next     = 1'b1;
                        kind_next       = msct_pkg::KIND_FIRE;
                        slot_next       = 3'(held_slot_reg);
                        last_next       = 1'b1;
                        held_valid_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            opt_reg        <= msct_pkg::PRESCALE_RESET;
            prescale_reg   <= msct_pkg::PRESCALE_RESET;
            active_reg     <= '0;
            idx_reg        <= '0;
            proc_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            opt_reg        <= opt_next;
            prescale_reg   <= prescale_next;
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            proc_valid_reg <= proc_valid_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        proc_idx_reg  <= proc_idx_next;
        held_slot_reg <= held_slot_next;
        op_reg        <= op_next;
        period_reg    <= period_next;
        rep_reg       <= rep_next;
        sel_reg       <= sel_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        last_reg      <= last_next;
    end

endmodule

@@ sv/msct_checker.sv @@
// Port-level checker for the multi-slot callback timer, with its bind.
`timescale 1ns / 1ps

module msct_assertions (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic       kind,
    input logic       last
);

    // An accepted command always keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a command");

    // A result word is only shown while the block reports busy
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result word shown while idle");

    // A set produces exactly one word, so it is always the final one
    a_set_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (kind == msct_pkg::KIND_SET)) |-> last)
        else $error("set result without last");

    // No result word appears in the cycle right after a command is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !strobe)
        else $error("result word too early after accept");

    // A word that is not final is followed by more work
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> busy)
        else $error("block idle after a non-final result word");

endmodule

bind multi_slot_callback_timer msct_assertions u_msct_assertions (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .kind   (kind),
    .last   (last)
);

@@ dv/msct_checker.sv @@
// Slot timer checker: predicts the report words from accepted commands and compares.
`timescale 1ns / 1ps

module msct_checker (
    input  logic        clk,
    input  logic        rst_n,
    // Command channel, observed
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] period,
    input  logic        repeating,
    input  logic [2:0]  slot_number,
    // Report channel, observed
    input  logic        strobe,
    input  logic        kind,
    input  logic [2:0]  slot,
    input  logic        last,
    // Register port, observed
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // Status toward the top
    output int          failures,
    output int          outstanding
);

    localparam int SLOTS = 8;

    typedef struct packed {
        logic       kind;
        logic [2:0] slot;
        logic       last;
    } slot_report_t;

    // Shadow of the slot table and the prescaler
    logic [15:0]  period_tab [SLOTS];
    logic [15:0]  count_tab  [SLOTS];
    logic         repeat_tab [SLOTS];
    logic [7:0]   prescale;
    logic [7:0]   tick_reload;

    slot_report_t reports_due[$];
    slot_report_t due_word;
    int           mismatch_count;

    // Apply one accepted command word to the shadow table and queue its reports
    task automatic apply_command(input logic [1:0] op, input logic [15:0] per,
                                 input logic rep, input logic [2:0] sel);
        int           idx;
        int           fired;
        slot_report_t batch [msct_pkg::MAX_RESULTS];
        unique case (op)
            msct_pkg::OP_SET:
            begin
                // claim the first free slot below the last one, else overwrite the last
                idx = SLOTS - 1;
                for (int i = SLOTS - 2; i >= 0; i--)
                begin
                    if (period_tab[i] == 16'd0)
                        idx = i;
                end
                count_tab[idx]  = per;
                repeat_tab[idx] = rep;
                period_tab[idx] = per;
                reports_due.push_back('{msct_pkg::KIND_SET, idx[2:0], 1'b1});
            end
            msct_pkg::OP_CLEAR:
            begin
                if (int'(sel) < SLOTS)
                    period_tab[sel] = 16'd0;
            end
            msct_pkg::OP_OVERFLOW:
            begin
                prescale = prescale - 8'd1;
                if (prescale == 8'd0)
                begin
                    prescale = tick_reload;
                    fired = 0;
                    // count down every active slot; fired ones reload or drop out
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (period_tab[i] != 16'd0)
                        begin
                            count_tab[i] = count_tab[i] - 16'd1;
                            if (count_tab[i] == 16'd0)
                            begin
                                if (fired < msct_pkg::MAX_RESULTS)
                                begin
                                    batch[fired] = '{msct_pkg::KIND_FIRE, i[2:0], 1'b0};
                                    fired++;
                                end
                                if (!repeat_tab[i])
                                    period_tab[i] = 16'd0;
                                else
                                    count_tab[i] = period_tab[i];
                            end
                        end
                    end
                    for (int k = 0; k < fired; k++)
                    begin
                        batch[k].last = (k == fired - 1);
                        reports_due.push_back(batch[k]);
                    end
                end
            end
            default:
            begin
                // unused opcode: no effect
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                period_tab[i] = 16'd0;
                count_tab[i]  = 16'd0;
                repeat_tab[i] = 1'b0;
            end
            prescale       = msct_pkg::PRESCALE_RESET;
            tick_reload    = msct_pkg::PRESCALE_RESET;
            mismatch_count = 0;
            reports_due.delete();
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            // compare a shown report word with the oldest one due
            if (strobe)
            begin
                if (reports_due.size() == 0)
                begin
                    $display("%0t: report word with none due: kind=%0d slot=%0d last=%0d",
                             $time, kind, slot, last);
                    mismatch_count++;
                end
                else
                begin
                    due_word = reports_due.pop_front();
                    if (kind !== due_word.kind || slot !== due_word.slot ||
                        last !== due_word.last)
                    begin
                        $display("%0t: expected %0d/%0d/%0d (kind/slot/last), got %0d/%0d/%0d",
                                 $time, due_word.kind, due_word.slot, due_word.last,
                                 kind, slot, last);
                        mismatch_count++;
                    end
                end
            end

            // take a register write; the prescaler picks it up at its next reload
            if (psel && penable && pwrite && pready &&
                paddr[2] == msct_pkg::REG_OVERFLOWS_PER_TICK)
                tick_reload = pwdata[7:0];

            // predict for an accepted command word
            if (start && !busy)
                apply_command(opcode, period, repeating, slot_number);

            failures    <= mismatch_count;
            outstanding <= reports_due.size();
        end
    end

endmodule

@@ dv/tb.sv @@
// Testbench top for the multi-slot callback timer: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         DRAIN_CYCLES = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  opcode = msct_pkg::OP_OVERFLOW;
    logic [15:0] period = 16'd0;
    logic        repeating = 1'b0;
    logic [2:0]  slot_number = 3'd0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;

    logic        busy;
    logic        strobe;
    logic        kind;
    logic [2:0]  slot;
    logic        last;
    logic [31:0] prdata;
    logic        pready;
    int          failures;
    int          outstanding;

    always #5 clk = ~clk;

    multi_slot_callback_timer #(
        .NUM_SLOTS (8)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .period      (period),
        .repeating   (repeating),
        .slot_number (slot_number),
        .strobe      (strobe),
        .kind        (kind),
        .slot        (slot),
        .last        (last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    msct_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .period      (period),
        .repeating   (repeating),
        .slot_number (slot_number),
        .strobe      (strobe),
        .kind        (kind),
        .slot        (slot),
        .last        (last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one command word and hold it until the block takes it
    task automatic send_word(input logic [1:0] op, input logic [15:0] per,
                             input logic rep, input logic [2:0] sel);
        start       <= 1'b1;
        opcode      <= op;
        period      <= per;
        repeating   <= rep;
        slot_number <= sel;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Drop start for a number of cycles
    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Wait until every due report word has been shown, then let the block go quiet
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the prescaler reload: setup cycle, then access cycle
    task automatic write_reload(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {msct_pkg::REG_OVERFLOWS_PER_TICK, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // One random command word: mostly overflows and sets with short periods
    task automatic send_random(input bit gaps);
        int          r;
        int          q;
        logic [1:0]  op;
        logic [15:0] per;
        r = $urandom_range(0, 99);
        if (r < 50)
            op = msct_pkg::OP_OVERFLOW;
        else if (r < 80)
            op = msct_pkg::OP_SET;
        else if (r < 95)
            op = msct_pkg::OP_CLEAR;
        else
            op = OP_UNUSED;
        q = $urandom_range(0, 9);
        if (q == 0)
            per = 16'd0;
        else if (q < 3)
            per = 16'($urandom);
        else
            per = 16'($urandom_range(1, 6));
        send_word(op, per, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        if (gaps)
            pause(pick_gap());
    endtask

    task automatic run_phase(input logic [7:0] reload, input int words, input bit gaps);
        write_reload(reload);
        repeat (words) send_random(gaps);
        settle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unused opcode with every field bit set: no effect
        send_word(OP_UNUSED, 16'hFFFF, 1'b1, 3'd7);
        pause(pick_gap());
        // zero period: slot 0 reported but left free
        send_word(msct_pkg::OP_SET, 16'd0, 1'b0, 3'd0);
        send_word(msct_pkg::OP_SET, 16'hFFFF, 1'b1, 3'd0);
        pause(pick_gap());
        for (int i = 1; i < 7; i++)
        begin
            send_word(msct_pkg::OP_SET, 16'd1, i[0], 3'd0);
            pause(pick_gap());
        end
        // table full below the last slot: the last slot is overwritten
        send_word(msct_pkg::OP_SET, 16'd2, 1'b1, 3'd0);
        send_word(msct_pkg::OP_SET, 16'd3, 1'b0, 3'd0);
        repeat (3) send_word(msct_pkg::OP_OVERFLOW, 16'h0000, 1'b0, 3'd0);
        settle();

        // new reload waits for the running prescale to expire
        write_reload(8'd1);
        repeat (4)
        begin
            send_word(msct_pkg::OP_OVERFLOW, 16'h5A5A, 1'b1, 3'd5);
            pause(pick_gap());
        end
        send_word(msct_pkg::OP_CLEAR, 16'd0, 1'b0, 3'd0);
        send_word(msct_pkg::OP_CLEAR, 16'd0, 1'b0, 3'd3);
        send_word(msct_pkg::OP_CLEAR, 16'd0, 1'b0, 3'd7);
        pause(pick_gap());
        // fill the table with period 1 so one tick fires every slot
        repeat (6) send_word(msct_pkg::OP_SET, 16'd1, 1'b0, 3'd0);
        send_word(msct_pkg::OP_OVERFLOW, 16'd0, 1'b0, 3'd0);
        settle();

        run_phase(8'd2, 40, 1'b1);
        run_phase(8'd3, 40, 1'b1);
        run_phase(8'd1, 40, 1'b1);
        run_phase(8'd1, 30, 1'b0);

        // reload 0: the next tick reloads zero, so the prescaler then wraps to 255
        write_reload(8'd0);
        send_word(msct_pkg::OP_SET, 16'd1, 1'b1, 3'd0);
        send_word(msct_pkg::OP_SET, 16'd2, 1'b0, 3'd0);
        send_word(msct_pkg::OP_OVERFLOW, 16'd0, 1'b0, 3'd0);
        repeat (27)
        begin
            send_word(msct_pkg::OP_OVERFLOW, 16'($urandom), 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)));
            pause(pick_gap());
        end
        settle();

        if (failures == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
